### rtl/adjacent_duplicate_line_filter_top_macros.svh
// Assertion macros for the adjacent duplicate line filter.
`ifndef ADJACENT_DUPLICATE_LINE_FILTER_TOP_MACROS_SVH
`define ADJACENT_DUPLICATE_LINE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ADLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ADLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/adlf_pkg.sv
// Shared types and constants of the adjacent duplicate line filter.
package adlf_pkg;

    localparam logic [7:0]  NEWLINE       = 8'd10;
    localparam logic [1:0]  MODE_SHOW     = 2'd1;
    localparam logic [1:0]  MODE_ONLY_REP = 2'd2;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic        REG_MODE      = 1'b0;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;       // input request taken this cycle
        logic close_dup;    // closed line equals previous: bump count
        logic swap;         // closed line starts a new group
        logic clear;        // end of stream: drop the pending group
        logic emit_load;    // load one result into the output register
        logic rd_emit;      // next read address follows the emit index
        logic last_group;   // group being emitted is the last one for this input
    } ctl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_nl;        // input byte is a newline
        logic is_dup;       // current line matches previous line
        logic emit_ok;      // pending group passes the mode filter
        logic emit_nl;      // emit index is on the closing newline
        logic out_free;     // output register can take a result
        logic out_valid;    // output register holds a result
        logic have_prev;
        logic count_nz;
    } dp_status_t;

endpackage

### rtl/adjacent_duplicate_line_filter_top.sv
// Top level of the adjacent duplicate line filter: APB register, controller, datapath.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+------------------------------------------
//   s_       | in        | s_valid / s_ready | s_text_byte, s_end_of_data
//   m_       | out       | m_valid / m_ready | m_out_byte, m_repeat_count, m_show_count,
//            |           |                   | m_end_of_line, m_last
//   apb      | in        | psel / penable    | paddr, pwrite, pwdata, prdata (pready = 1)
//
// A newline or end-of-data request adds a close step after the byte is taken.
// A group flush emits one result per cycle, while m_ready allows, from the line store's
// single registered read port; at end of stream ST_FINAL comes before the final group.
// s_ready is low during close and flush; a stalled m_ready holds the flush in place.
// Reset is synchronous, active low; the line store itself is not cleared.
// The result register frees the input side while the last result waits to be taken.
module adjacent_duplicate_line_filter_top import adlf_pkg::*; #(
    parameter int LINE_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_repeat_count,
    output logic        m_show_count,
    output logic        m_end_of_line,
    output logic        m_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] mode_reg, mode_next;
    logic       reg_hit;
    ctl_cmd_t   cmd;
    dp_status_t status;

    // Word index is paddr[2]; only the mode register exists.
    assign reg_hit = (paddr[2] == REG_MODE);

    assign mode_next = (psel && penable && pwrite && reg_hit) ? pwdata[1:0] : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 2'd0;
        end else begin
            mode_reg <= mode_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? {30'd0, mode_reg} : 32'd0;

    adlf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .mode          (mode_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_end_of_data (s_end_of_data),
        .status        (status),
        .cmd           (cmd)
    );

    adlf_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .mode           (mode_reg),
        .cmd            (cmd),
        .status         (status),
        .s_text_byte    (s_text_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_repeat_count (m_repeat_count),
        .m_show_count   (m_show_count),
        .m_end_of_line  (m_end_of_line),
        .m_last         (m_last)
    );

endmodule

### rtl/adlf_datapath.sv
// Line store, group state and output register of the line filter.
module adlf_datapath import adlf_pkg::*; #(
    parameter int LINE_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  mode,
    input  ctl_cmd_t    cmd,
    output dp_status_t  status,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_repeat_count,
    output logic        m_show_count,
    output logic        m_end_of_line,
    output logic        m_last
);

    localparam int LEN_W  = $clog2(LINE_BYTES);
    localparam int ADDR_W = LEN_W + 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LINE_BYTES - 1);

    // Two banks: address MSB is the bank, previous line lives in bank_reg.
    logic [7:0]        mem [2**ADDR_W];
    logic [7:0]        rd_q;
    logic [ADDR_W-1:0] rd_addr;

    logic              bank_reg, bank_next;
    logic [LEN_W-1:0]  prev_len_reg, prev_len_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic              match_reg, match_next;
    logic [15:0]       count_reg, count_next;
    logic              have_prev_reg, have_prev_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        out_byte_reg;
    logic [15:0]       count_out_reg;
    logic              show_reg, eol_reg, last_reg;

    logic              is_nl, do_append, emit_nl;

    assign is_nl     = (s_text_byte == NEWLINE);
    assign do_append = cmd.accept && !is_nl && (cur_len_reg != MAX_LEN);
    assign emit_nl   = (idx_reg == prev_len_reg);

    always_comb begin
        bank_next      = bank_reg;
        prev_len_next  = prev_len_reg;
        cur_len_next   = cur_len_reg;
        match_next     = match_reg;
        count_next     = count_reg;
        have_prev_next = have_prev_reg;
        idx_next       = idx_reg;
        if (do_append) begin
            cur_len_next = cur_len_reg + LEN_W'(1);
            if ((cur_len_reg >= prev_len_reg) || (rd_q != s_text_byte)) begin
                match_next = 1'b0;
            end
        end
        if (cmd.close_dup) begin
            if (count_reg != COUNT_MAX) begin
                count_next = count_reg + 16'd1;
            end
            cur_len_next = '0;
            match_next   = 1'b1;
        end
        if (cmd.swap) begin
            bank_next      = ~bank_reg;
            prev_len_next  = cur_len_reg;
            count_next     = 16'd1;
            have_prev_next = 1'b1;
            cur_len_next   = '0;
            match_next     = 1'b1;
        end
        if (cmd.clear) begin
            have_prev_next = 1'b0;
            count_next     = '0;
            prev_len_next  = '0;
            cur_len_next   = '0;
            match_next     = 1'b1;
        end
        if (cmd.emit_load) begin
            idx_next = emit_nl ? '0 : idx_reg + LEN_W'(1);
        end
    end

    // Read address tracks next-cycle state so rd_q is current every cycle.
    assign rd_addr = cmd.rd_emit ? {bank_next, idx_next} : {bank_next, cur_len_next};

    always_ff @(posedge aclk) begin
        if (do_append) begin
            mem[{~bank_reg, cur_len_reg}] <= s_text_byte;
        end
        rd_q <= mem[rd_addr];
    end

    assign m_valid_next = cmd.emit_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg      <= 1'b0;
            prev_len_reg  <= '0;
            cur_len_reg   <= '0;
            match_reg     <= 1'b1;
            count_reg     <= '0;
            have_prev_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            bank_reg      <= bank_next;
            prev_len_reg  <= prev_len_next;
            cur_len_reg   <= cur_len_next;
            match_reg     <= match_next;
            count_reg     <= count_next;
            have_prev_reg <= have_prev_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_byte_reg  <= emit_nl ? NEWLINE : rd_q;
            count_out_reg <= count_reg;
            show_reg      <= (mode == MODE_SHOW);
            eol_reg       <= emit_nl;
            last_reg      <= emit_nl && cmd.last_group;
        end
    end

    assign status.is_nl     = is_nl;
    assign status.is_dup    = have_prev_reg && match_reg && (cur_len_reg == prev_len_reg);
    assign status.emit_ok   = have_prev_reg &&
                              !((mode == MODE_ONLY_REP) && (count_reg < 16'd2));
    assign status.emit_nl   = emit_nl;
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.out_valid = m_valid_reg;
    assign status.have_prev = have_prev_reg;
    assign status.count_nz  = (count_reg != 16'd0);

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_repeat_count = count_out_reg;
    assign m_show_count   = show_reg;
    assign m_end_of_line  = eol_reg;
    assign m_last         = last_reg;

endmodule

### rtl/adlf_ctrl.sv
// Sequencing state machine of the line filter.
`include "adjacent_duplicate_line_filter_top_macros.svh"

module adlf_ctrl import adlf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_end_of_data,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_EMIT,
        ST_FINAL
    } state_t;

    state_t state_reg, state_next;
    logic   eod_reg, eod_next;
    logic   final_reg, final_next;

    always_comb begin
        state_next = state_reg;
        eod_next   = eod_reg;
        final_next = final_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid) begin
                    eod_next = s_end_of_data;
                    if (status.is_nl || s_end_of_data) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (status.is_dup) begin
                    cmd.close_dup = 1'b1;
                    state_next    = eod_reg ? ST_FINAL : ST_IDLE;
                end else if (status.emit_ok) begin
                    cmd.rd_emit = 1'b1;
                    final_next  = 1'b0;
                    state_next  = ST_EMIT;
                end else begin
                    cmd.swap   = 1'b1;
                    state_next = eod_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (status.emit_ok) begin
                    cmd.rd_emit = 1'b1;
                    final_next  = 1'b1;
                    state_next  = ST_EMIT;
                end else begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                cmd.emit_load  = status.out_free;
                cmd.rd_emit    = 1'b1;
                // A later group follows only at end of stream with a printable new line.
                cmd.last_group = final_reg || !eod_reg || (mode == MODE_ONLY_REP);
                if (status.out_free && status.emit_nl) begin
                    cmd.rd_emit = 1'b0;
                    if (final_reg) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.swap   = 1'b1;
                        state_next = eod_reg ? ST_FINAL : ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            eod_reg   <= 1'b0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            eod_reg   <= eod_next;
            final_reg <= final_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    `ADLF_ASSERT_NEXT(a_eod_closes, s_valid && s_ready && s_end_of_data, state_reg == ST_CLOSE, "end of data did not close the line")
    `ADLF_ASSERT_NEXT(a_emit_fills, (state_reg == ST_EMIT) && status.out_free, status.out_valid, "emit step left output register empty")
    `ADLF_ASSERT_NOW(a_group_count, 1'b1, status.have_prev == status.count_nz, "group count disagrees with pending group")

endmodule

### sim/adjacent_duplicate_line_filter_top_test.sv
// Self-checking testbench of the line filter: random text streams against a predictor.
module adjacent_duplicate_line_filter_top_test;
    import adlf_pkg::*;

    localparam int LINE_BYTES = 32;
    // Stored content of one line; the rest of a long line is dropped.
    localparam int KEEP_BYTES = LINE_BYTES - 1;
    // Mode values the package does not name.
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // After the last result a close or flush cycle may still be in flight.
    localparam int DRAIN_CYCLES = 20;
    // Longest correct quiet stretch: the longest bursty receiver stall, the longest sender gap,
    // the drain pause and an APB write. This limit is many times that.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] ch;
        logic       eod;
    } text_item_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic [15:0] count;
        logic        show;
        logic        eol;
        logic        last;
    } line_result_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_style_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        s_end_of_data;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic [15:0] m_repeat_count;
    logic        m_show_count;
    logic        m_end_of_line;
    logic        m_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    adjacent_duplicate_line_filter_top #(.LINE_BYTES(LINE_BYTES)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_end_of_data  (s_end_of_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_repeat_count (m_repeat_count),
        .m_show_count   (m_show_count),
        .m_end_of_line  (m_end_of_line),
        .m_last         (m_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    text_item_t   text_q[$];       // requests waiting for the driver
    line_result_t expected_q[$];   // predicted results, oldest first
    int queued_total  = 0;         // requests put in text_q so far
    int taken_total   = 0;         // requests the block accepted
    int result_total  = 0;         // results the block delivered
    int fail_count    = 0;
    int idle_cycles   = 0;
    bit in_taken      = 1'b0;      // request handshake at the last rising edge

    // ------------------------------------------------------------------
    // Predictor: a copy of the line grouping state, lengths held wider than the block's widths
    // ------------------------------------------------------------------
    logic [7:0]  line_mem [0:2*LINE_BYTES-1];  // two banks, bank_sel holds the previous line
    logic [5:0]  prev_len;
    logic [5:0]  cur_len;
    logic        matching;
    logic [15:0] grp_count;
    logic        have_prev;
    logic        bank_sel;
    logic [1:0]  filter_mode;

    line_result_t flush_buf [0:2*LINE_BYTES-1];  // results of the request being modeled
    int           flush_n;

    initial begin
        prev_len    = '0;
        cur_len     = '0;
        matching    = 1'b1;
        grp_count   = '0;
        have_prev   = 1'b0;
        bank_sel    = 1'b0;
        filter_mode = MODE_PLAIN;
    end

    task automatic push_result(input logic [7:0] ch, input logic eol);
        flush_buf[flush_n] = '{ch: ch, count: grp_count, show: filter_mode == MODE_SHOW,
                               eol: eol, last: 1'b0};
        flush_n++;
    endtask

    // Emit the pending group, unless the mode filters out single lines.
    task automatic flush_group();
        int base;
        if (!have_prev)
            return;
        if (filter_mode == MODE_ONLY_REP && grp_count < 16'd2)
            return;
        base = bank_sel ? LINE_BYTES : 0;
        for (int k = 0; k < prev_len && k < KEEP_BYTES; k++)
            push_result(line_mem[base + k], 1'b0);
        push_result(NEWLINE, 1'b1);
    endtask

    // Advance the grouping state by one accepted request and queue its results.
    task automatic track_request(input logic [7:0] ch, input logic eod);
        int prev_base;
        int cur_base;
        line_result_t r;
        prev_base = bank_sel ? LINE_BYTES : 0;
        cur_base  = bank_sel ? 0 : LINE_BYTES;
        flush_n   = 0;
        // content byte: compare against the previous line, store unless truncated
        if (ch != NEWLINE && cur_len < KEEP_BYTES) begin
            if (cur_len >= prev_len || line_mem[prev_base + cur_len] != ch)
                matching = 1'b0;
            line_mem[cur_base + cur_len] = ch;
            cur_len++;
        end
        // line closes on newline, or on end of data as if a newline followed
        if (ch == NEWLINE || eod) begin
            if (have_prev && matching && cur_len == prev_len) begin
                if (grp_count != COUNT_MAX)
                    grp_count++;
            end else begin
                flush_group();
                bank_sel  = ~bank_sel;
                prev_len  = cur_len;
                grp_count = 16'd1;
                have_prev = 1'b1;
            end
            cur_len  = '0;
            matching = 1'b1;
        end
        // end of stream flushes the open group and starts over
        if (eod) begin
            flush_group();
            have_prev = 1'b0;
            grp_count = '0;
            prev_len  = '0;
            cur_len   = '0;
            matching  = 1'b1;
        end
        for (int i = 0; i < flush_n; i++) begin
            r = flush_buf[i];
            r.last = (i == flush_n - 1);
            expected_q.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted request, checks each result
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        line_result_t want;
        bit moved;
        moved    = 1'b0;
        in_taken = 1'b0;
        if (aresetn) begin
            // request first, so a same-edge result would still find its expectation
            if (s_valid && s_ready) begin
                in_taken = 1'b1;
                moved    = 1'b1;
                taken_total++;
                track_request(s_text_byte, s_end_of_data);
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                result_total++;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected, got byte %0d count %0d",
                             $time, m_out_byte, m_repeat_count);
                    $display("%0t: eol %0b last %0b", $time, m_end_of_line, m_last);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_byte", want.ch, m_out_byte);
                    check_field("repeat_count", want.count, m_repeat_count);
                    check_field("show_count", want.show, m_show_count);
                    check_field("end_of_line", want.eol, m_end_of_line);
                    check_field("last", want.last, m_last);
                end
            end
            if (psel && penable)
                moved = 1'b1;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results still expected",
                         $time, idle_cycles, expected_q.size());
                $display("adjacent_duplicate_line_filter_top_test: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of requests with random gaps, fed from text_q
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        logic       nv;
        logic [7:0] nb;
        logic       ne;
        text_item_t item;
        nv = s_valid;
        nb = s_text_byte;
        ne = s_end_of_data;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (!s_valid || in_taken) begin
            // previous request gone (or none): pick the next one or idle
            nv = 1'b0;
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (text_q.size() != 0) begin
                item = text_q.pop_front();
                nv   = 1'b1;
                nb   = item.ch;
                ne   = item.eod;
                burst_left--;
            end
        end
        s_valid       <= nv;
        s_text_byte   <= nb;
        s_end_of_data <= ne;
    end

    // ------------------------------------------------------------------
    // Receiver: open, random or bursty m_ready, the style redrawn after a random run of cycles
    // ------------------------------------------------------------------
    rx_style_t rx_style  = RX_OPEN;
    int        style_left = 0;
    int        run_left   = 0;
    logic      run_val    = 1'b1;

    always @(negedge aclk) begin
        logic nr;
        if (style_left == 0) begin
            rx_style   = rx_style_t'($urandom_range(0, 2));
            style_left = $urandom_range(50, 200);
        end
        style_left--;
        case (rx_style)
            RX_OPEN: begin
                nr = 1'b1;
            end
            RX_RANDOM: begin
                nr = 1'($urandom_range(0, 1));
            end
            default: begin
                if (run_left == 0) begin
                    run_val  = ~run_val;
                    run_left = $urandom_range(1, 16);
                end
                run_left--;
                nr = run_val;
            end
        endcase
        m_ready <= nr;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic [7:0] ch, input logic eod);
        text_q.push_back('{ch: ch, eod: eod});
        queued_total++;
    endtask

    // APB write of the mode register: setup, then access; pready is always high.
    task automatic write_mode(input logic [1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_MODE);
        pwdata  <= {30'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        filter_mode = value;
    endtask

    // Wait until every request is taken and every result checked, then let
    // any close or flush cycle finish.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (text_q.size() != 0 || taken_total != queued_total || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One well-formed stream: lines drawn from a small pool so that adjacent
    // repeats are common. Optionally two long lines that agree in their kept
    // part and differ only past the truncation point.
    task automatic add_random_stream(input int n_lines, input bit with_long);
        logic [7:0] pool [4][40];
        int         plen [4];
        int         pick;
        int         prev_pick;
        int         idx;
        bit         closing;
        bit         unterm;
        logic [7:0] c;
        for (int p = 0; p < 4; p++) begin
            plen[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 6);
            for (int k = 0; k < 40; k++) begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == NEWLINE);
                pool[p][k] = c;
            end
        end
        if (with_long) begin
            plen[2] = $urandom_range(KEEP_BYTES, 40);
            plen[3] = plen[2];
            pool[3] = pool[2];
            if (plen[3] > KEEP_BYTES) begin
                idx = $urandom_range(KEEP_BYTES, plen[3] - 1);
                pool[3][idx] = (pool[2][idx] == 8'h20) ? 8'h21 : 8'h20;
            end
        end
        unterm    = 1'($urandom_range(0, 1));
        prev_pick = 0;
        for (int l = 0; l < n_lines; l++) begin
            pick    = ($urandom_range(0, 2) == 0) ? prev_pick : $urandom_range(0, 3);
            closing = (l == n_lines - 1);
            for (int k = 0; k < plen[pick]; k++)
                add_item(pool[pick][k], closing && unterm && k == plen[pick] - 1);
            if (!(closing && unterm && plen[pick] > 0))
                add_item(NEWLINE, closing);
            prev_pick = pick;
        end
    endtask

    // Optionally one short stream with long lines, then well-formed streams up
    // to the budget, then a burst of raw bytes with stray newlines and ends of
    // stream; always closes the stream at the end.
    task automatic add_random_phase(input int budget, input bit with_long);
        int start;
        int n_noise;
        start = queued_total;
        if (with_long)
            add_random_stream(3, 1'b1);
        while (queued_total - start < budget)
            add_random_stream($urandom_range(2, 8), 1'b0);
        n_noise = $urandom_range(5, 10);
        for (int i = 0; i < n_noise; i++)
            add_item(($urandom_range(0, 4) == 0) ? NEWLINE : 8'($urandom_range(0, 255)),
                     i == n_noise - 1 || $urandom_range(0, 15) == 0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_text_byte   = '0;
        s_end_of_data = 1'b0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty lines, byte extremes, a repeated line, an
        // unterminated last line, a lone newline stream, a one-byte stream.
        write_mode(MODE_PLAIN);
        add_item(NEWLINE, 1'b0);
        add_item(NEWLINE, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(NEWLINE, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(NEWLINE, 1'b0);
        add_item(8'h7F, 1'b0);
        add_item(8'h80, 1'b1);
        add_item(NEWLINE, 1'b1);
        add_item(8'h41, 1'b1);
        wait_drained();

        // Random streams under every mode, including the unused code.
        write_mode(MODE_SHOW);
        add_random_phase(0, 1'b1);
        wait_drained();
        write_mode(MODE_ONLY_REP);
        add_random_phase(16, 1'b0);
        wait_drained();
        write_mode(MODE_SPARE);
        add_random_phase(16, 1'b0);
        wait_drained();
        write_mode(MODE_PLAIN);
        add_random_phase(16, 1'b0);
        wait_drained();

        $display("Ran %0d requests and checked %0d results across modes 0 to 3,", taken_total,
                 result_total);
        $display("with long, empty and unterminated lines and stray ends of stream.");
        if (fail_count == 0) begin
            $display("adjacent_duplicate_line_filter_top_test: PASS");
        end else begin
            $display("adjacent_duplicate_line_filter_top_test: FAIL");
        end
        $finish;
    end

endmodule
